/* rtl/esckv_pkg.sv */
package esckv_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned NUM_LITS     = 5;
  localparam int unsigned LIT_SLOTS    = 8;
  localparam int unsigned MAX_TOKEN    = 9;

  typedef logic [7:0] char_t;
  typedef logic [3:0] count_t;
  typedef logic [NUM_LITS-1:0] lit_flags_t;

  typedef enum logic [2:0] {
    CLS_INVALID = 3'd0,
    CLS_CHAT    = 3'd1,
    CLS_LOGIN   = 3'd2,
    CLS_STAT    = 3'd3,
    CLS_ENTER   = 3'd4,
    CLS_OTHER   = 3'd5
  } msg_class_t;

  localparam int unsigned LIT_TYPE = 0;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SLASH = 8'h2f;
  localparam char_t CH_AT    = 8'h40;
  localparam char_t CH_A     = 8'h41;
  localparam char_t CH_S     = 8'h53;
  localparam char_t CH_EQ    = 8'h3d;

  localparam lit_flags_t ALL_FLAGS = '1;

  // literals in flag order: type, chatmsg, loginres, rss, uenter
  localparam char_t LIT_TEXT [NUM_LITS][LIT_SLOTS] = '{
    '{"t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "t", "m", "s", "g", 8'h00},
    '{"l", "o", "g", "i", "n", "r", "e", "s"},
    '{"r", "s", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"u", "e", "n", "t", "e", "r", 8'h00, 8'h00}
  };

  localparam count_t LIT_LEN [NUM_LITS] = '{4'd4, 4'd7, 4'd8, 4'd3, 4'd6};

endpackage

/* rtl/escaped_kv_message_classifier_core.sv */
// The class appears on out_ in the cycle after the packet's last byte is accepted.
// Throughput: one byte per cycle; in_ready drops only while a class waits unaccepted.
// The byte-level match is a single combinational pass into the state registers.
// Reset (synchronous, rst_n low) clears scan state, match flags and out_valid.
// Scan state also returns to its reset values after every last byte.
module escaped_kv_message_classifier_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  esckv_pkg::char_t     in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_msg_class
);
  import esckv_pkg::*;

  count_t     byte_count_r,   byte_count_nxt;
  logic       scan_done_r,    scan_done_nxt;
  logic       escape_r,       escape_nxt;
  count_t     token_len_r,    token_len_nxt;
  lit_flags_t flags_r,        flags_nxt;
  logic       key_is_type_r,  key_is_type_nxt;
  msg_class_t found_r,        found_nxt;
  logic       out_valid_r,    out_valid_nxt;
  msg_class_t out_class_r,    out_class_nxt;

  logic       in_fire;
  logic       in_header;
  logic       do_append;
  char_t      append_c;
  lit_flags_t keep;
  lit_flags_t lit_full;
  msg_class_t value_class;
  msg_class_t found_end;

  assign in_ready      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_msg_class = out_class_r;
  assign in_header     = byte_count_r < count_t'(HEADER_BYTES);
  assign append_c      = !escape_r ? in_data_byte :
                         (in_data_byte == CH_S) ? CH_SLASH : CH_AT;

  always_comb begin
    for (int i = 0; i < NUM_LITS; i++) begin
      lit_full[i] = flags_r[i] && (token_len_r == LIT_LEN[i]);
      keep[i]     = (token_len_r < LIT_LEN[i]) &&
                    (LIT_TEXT[i][token_len_r[2:0]] == append_c);
    end
  end

  always_comb begin
    value_class = CLS_OTHER;
    if (!key_is_type_r || token_len_r == '0) begin
      value_class = CLS_INVALID;
    end else if (lit_full[1]) begin
      value_class = CLS_CHAT;
    end else if (lit_full[2]) begin
      value_class = CLS_LOGIN;
    end else if (lit_full[3]) begin
      value_class = CLS_STAT;
    end else if (lit_full[4]) begin
      value_class = CLS_ENTER;
    end
  end

  always_comb begin
    byte_count_nxt  = byte_count_r;
    scan_done_nxt   = scan_done_r;
    escape_nxt      = escape_r;
    token_len_nxt   = token_len_r;
    flags_nxt       = flags_r;
    key_is_type_nxt = key_is_type_r;
    found_nxt       = found_r;
    found_end       = found_r;
    do_append       = 1'b0;

    if (in_fire) begin
      if (in_header) begin
        byte_count_nxt = byte_count_r + 4'd1;
      end else if (!scan_done_r) begin
        if (in_data_byte == CH_NUL) begin
          scan_done_nxt = 1'b1;
          escape_nxt    = 1'b0;
        end else if (escape_r) begin
          escape_nxt = 1'b0;
          priority if (in_data_byte == CH_A) begin
            do_append = 1'b1;
          end else if (in_data_byte == CH_S) begin
            do_append = 1'b1;
          end else if (in_data_byte == CH_EQ) begin
            key_is_type_nxt = lit_full[LIT_TYPE];
            token_len_nxt   = '0;
            flags_nxt       = ALL_FLAGS;
          end else begin
            // unknown escape: byte consumed, nothing added
          end
        end else if (in_data_byte == CH_SLASH) begin
          found_nxt     = value_class;
          scan_done_nxt = 1'b1;
        end else if (in_data_byte == CH_AT) begin
          escape_nxt = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end

      if (do_append) begin
        flags_nxt = flags_r & keep;
        if (token_len_r < count_t'(MAX_TOKEN)) begin
          token_len_nxt = token_len_r + 4'd1;
        end
      end

      found_end = found_nxt;

      if (in_last_byte) begin
        byte_count_nxt  = '0;
        scan_done_nxt   = 1'b0;
        escape_nxt      = 1'b0;
        token_len_nxt   = '0;
        flags_nxt       = ALL_FLAGS;
        key_is_type_nxt = 1'b0;
        found_nxt       = CLS_INVALID;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_class_nxt = out_class_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_class_nxt = found_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      scan_done_r   <= 1'b0;
      escape_r      <= 1'b0;
      token_len_r   <= '0;
      flags_r       <= ALL_FLAGS;
      key_is_type_r <= 1'b0;
      found_r       <= CLS_INVALID;
      out_valid_r   <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      scan_done_r   <= scan_done_nxt;
      escape_r      <= escape_nxt;
      token_len_r   <= token_len_nxt;
      flags_r       <= flags_nxt;
      key_is_type_r <= key_is_type_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
  end

`ifndef SYNTH
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> (out_valid_r && byte_count_r == '0 && !scan_done_r))
    else $error("scan state not restarted after last byte");

  a_token_sat: assert property (@(posedge clk) disable iff (!rst_n)
    token_len_r <= count_t'(MAX_TOKEN))
    else $error("token length past saturation");

  a_header_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= count_t'(HEADER_BYTES))
    else $error("header count past header length");

  a_escape_open: assert property (@(posedge clk) disable iff (!rst_n)
    escape_r |-> !scan_done_r)
    else $error("escape pending after scan end");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r != CLS_INVALID) |-> scan_done_r)
    else $error("class decided without pair end");
`endif

endmodule

/* dv/escaped_kv_message_classifier_core_tb.sv */
module escaped_kv_message_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esckv_pkg::*;

  localparam int LONG_HOLD   = 200;
  localparam int TIMEOUT_NS  = 2_000_000;

  typedef struct packed {
    char_t data;
    logic  last;
  } byte_req_t;

  localparam msg_class_t LIT_CLASS [NUM_LITS] =
    '{CLS_INVALID, CLS_CHAT, CLS_LOGIN, CLS_STAT, CLS_ENTER};
  localparam string VALUE_NAMES [4] = '{"chatmsg", "loginres", "rss", "uenter"};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  char_t      in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_msg_class;

  escaped_kv_message_classifier_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_msg_class(out_msg_class)
  );

  always #2 clk = ~clk;

  // request stream and expected classes
  byte_req_t  byte_reqs[$];
  msg_class_t pending_classes[$];
  char_t      pkt_buf[$];

  int tx_gap_max = 10;
  int rx_gap_max = 10;
  int holds_asked = 0;
  int holds_done = 0;
  int err_count = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int classes_seen = 0;
  int class_hits[8];

  // scan state of the predictor
  count_t     hdr_seen;
  logic       pair_closed;
  logic       esc_open;
  count_t     tok_len;
  lit_flags_t tok_flags;
  logic       key_ok;
  msg_class_t cls_found;

  function automatic void clear_scan();
    hdr_seen    = '0;
    pair_closed = 1'b0;
    esc_open    = 1'b0;
    tok_len     = '0;
    tok_flags   = ALL_FLAGS;
    key_ok      = 1'b0;
    cls_found   = CLS_INVALID;
  endfunction

  function automatic logic full_match(int i);
    return tok_flags[i] && (tok_len == LIT_LEN[i]);
  endfunction

  function automatic void add_char(char_t c);
    lit_flags_t keep;
    keep = '0;
    for (int i = 0; i < NUM_LITS; i++) begin
      if (tok_len < LIT_LEN[i]) begin
        if (LIT_TEXT[i][tok_len[2:0]] == c) keep[i] = 1'b1;
      end
    end
    tok_flags = tok_flags & keep;
    if (tok_len < MAX_TOKEN) tok_len = tok_len + 1'b1;
  endfunction

  function automatic msg_class_t value_class();
    msg_class_t cls;
    cls = CLS_OTHER;
    if (!key_ok || tok_len == 0) return CLS_INVALID;
    for (int i = NUM_LITS - 1; i >= 1; i--) begin
      if (full_match(i)) cls = LIT_CLASS[i];
    end
    return cls;
  endfunction

  function automatic void scan_body(char_t c);
    if (c == CH_NUL) begin
      pair_closed = 1'b1;
      esc_open    = 1'b0;
    end else if (esc_open) begin
      esc_open = 1'b0;
      if (c == CH_A) begin
        add_char(CH_AT);
      end else if (c == CH_S) begin
        add_char(CH_SLASH);
      end else if (c == CH_EQ) begin
        key_ok    = full_match(LIT_TYPE);
        tok_len   = '0;
        tok_flags = ALL_FLAGS;
      end
    end else if (c == CH_SLASH) begin
      cls_found   = value_class();
      pair_closed = 1'b1;
    end else if (c == CH_AT) begin
      esc_open = 1'b1;
    end else begin
      add_char(c);
    end
  endfunction

  function automatic void track_byte(char_t c, logic last);
    if (hdr_seen < HEADER_BYTES) hdr_seen = hdr_seen + 1'b1;
    else if (!pair_closed) scan_body(c);
    if (last) begin
      pending_classes.push_back(cls_found);
      clear_scan();
    end
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_class(logic [2:0] got);
    msg_class_t want;
    if (pending_classes.size() == 0) begin
      flag_mismatch($sformatf("class %0d with no packet pending", got));
    end else begin
      want = pending_classes.pop_front();
      if (got !== want)
        flag_mismatch($sformatf("packet %0d: class %0d, expected %0d (%s)",
                                classes_seen, got, want, want.name()));
    end
    class_hits[got]++;
    classes_seen++;
  endtask

  // driver
  byte_req_t tx_next;
  int        tx_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_byte(in_data_byte, in_last_byte);
        bytes_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold request until taken
      end else if (tx_wait != 0) begin
        tx_wait  <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (byte_reqs.size() != 0) begin
        tx_next      = byte_reqs.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= tx_next.data;
        in_last_byte <= tx_next.last;
        tx_wait      <= $urandom_range(0, tx_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int rx_wait;
  int rx_draw;
  int hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) check_class(out_msg_class);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done <= holds_done + 1;
        hold_left  <= LONG_HOLD;
        out_ready  <= 1'b0;
      end else if (out_valid && out_ready) begin
        rx_draw = $urandom_range(0, rx_gap_max);
        rx_wait   <= rx_draw;
        out_ready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait   <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // packet building
  task automatic put_raw(char_t c);
    pkt_buf.push_back(c);
  endtask

  task automatic put_raw_str(string s);
    for (int i = 0; i < s.len(); i++) pkt_buf.push_back(char_t'(s[i]));
  endtask

  task automatic put_char(char_t c);
    if (c == CH_AT) begin
      put_raw(CH_AT);
      put_raw(CH_A);
    end else if (c == CH_SLASH) begin
      put_raw(CH_AT);
      put_raw(CH_S);
    end else begin
      put_raw(c);
    end
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(char_t'(s[i]));
  endtask

  task automatic put_rand_text(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) put_char(char_t'($urandom_range(8'h61, 8'h7a)));
      else put_char(char_t'($urandom_range(1, 255)));
    end
  endtask

  task automatic put_key_end();
    put_raw(CH_AT);
    put_raw(CH_EQ);
  endtask

  task automatic put_header();
    for (int i = 0; i < HEADER_BYTES; i++) put_raw(char_t'($urandom_range(0, 255)));
  endtask

  task automatic put_fill_header(char_t v);
    for (int i = 0; i < HEADER_BYTES; i++) put_raw(v);
  endtask

  task automatic flush_packet();
    byte_req_t r;
    for (int i = 0; i < pkt_buf.size(); i++) begin
      r.data = pkt_buf[i];
      r.last = (i == pkt_buf.size() - 1);
      byte_reqs.push_back(r);
    end
    bytes_queued += pkt_buf.size();
    pkt_buf.delete();
  endtask

  task automatic directed_pkt(string body);
    put_header();
    put_raw_str(body);
    flush_packet();
  endtask

  task automatic header_only_pkt();
    int n;
    n = $urandom_range(1, HEADER_BYTES);
    for (int i = 0; i < n; i++) put_raw(char_t'($urandom_range(0, 255)));
    flush_packet();
  endtask

  task automatic noise_pkt();
    int n;
    int k;
    put_header();
    n = $urandom_range(0, 16);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 11);
      case (k)
        0: put_raw(CH_AT);
        1: put_raw(CH_SLASH);
        2: put_raw(CH_EQ);
        3: put_raw(CH_A);
        4: put_raw(CH_S);
        5: put_raw(CH_NUL);
        6: put_raw_str("t");
        7: put_raw_str("y");
        8: put_raw_str("p");
        9: put_raw_str("e");
        default: put_raw(char_t'($urandom_range(0, 255)));
      endcase
    end
    flush_packet();
  endtask

  task automatic kv_pkt();
    string name;
    int    k;
    put_header();
    if ($urandom_range(0, 6) == 0) begin
      put_rand_text($urandom_range(0, 4));
      put_key_end();
    end
    case ($urandom_range(0, 9))
      7:       put_text("typ");
      8:       put_text("types");
      9:       put_rand_text($urandom_range(0, 6));
      default: put_text("type");
    endcase
    if ($urandom_range(0, 9) != 0) put_key_end();
    name = VALUE_NAMES[$urandom_range(0, 3)];
    k = $urandom_range(1, name.len() - 1);
    case ($urandom_range(0, 9))
      4: put_text(name.substr(0, k - 1));
      5: begin
        put_text(name);
        put_rand_text($urandom_range(1, 3));
      end
      6: put_rand_text($urandom_range(1, 12));
      7: ;
      8: begin
        put_text(name.substr(0, k - 1));
        put_rand_text(1);
        put_text(name.substr(k + 1, name.len() - 1));
      end
      9: begin
        put_raw(CH_AT);
        put_raw(char_t'($urandom_range(0, 255)));
        put_text(name);
      end
      default: put_text(name);
    endcase
    k = $urandom_range(0, 19);
    if (k < 14) put_raw(CH_SLASH);
    else if (k < 16) put_raw(CH_NUL);
    else if (k < 17) begin
      put_raw(CH_AT);
      put_raw(CH_NUL);
    end else if (k < 18) begin
      put_raw(CH_AT);
      flush_packet();
      return;
    end
    if (k < 17) begin
      k = $urandom_range(0, 5);
      for (int i = 0; i < k; i++) put_raw(char_t'($urandom_range(0, 255)));
    end
    if (pkt_buf.size() == 0) put_raw(CH_NUL);
    flush_packet();
  endtask

  task automatic random_pkt();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) kv_pkt();
    else if (k < 17) noise_pkt();
    else header_only_pkt();
  endtask

  task automatic wait_idle();
    while (byte_reqs.size() != 0 || in_valid || pending_classes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(int n_bytes, int tx_max, int rx_max);
    int goal;
    @(negedge clk);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    goal = bytes_queued + n_bytes;
    while (bytes_queued < goal) random_pkt();
    wait_idle();
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("status: fail");
    $finish;
  end

  initial begin
    clear_scan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed packets
    put_raw(8'hff);
    flush_packet();
    put_fill_header(8'h00);
    flush_packet();
    put_fill_header(8'hff);
    put_raw_str("type@=chatmsg/");
    flush_packet();
    put_fill_header(8'h00);
    put_raw_str("type@=loginres/");
    flush_packet();
    directed_pkt("type@=rss/");
    directed_pkt("type@=uenter/");
    directed_pkt("type@=hello/");
    directed_pkt("type@=/");
    directed_pkt("name@=chatmsg/");
    directed_pkt("chatmsg/");
    directed_pkt("type@=chatmsg");
    put_header();
    put_raw_str("type@=uenter");
    put_raw(CH_NUL);
    put_raw_str("/x");
    flush_packet();
    directed_pkt("type@=rs@/s/");
    directed_pkt("type@=r@@ss/");
    put_header();
    put_raw_str("type@=rss@");
    put_raw(CH_NUL);
    put_raw_str("/");
    flush_packet();
    directed_pkt("type@=rss@");
    directed_pkt("x@=type@=rss/");
    directed_pkt("type@=abc@=rss/");
    directed_pkt("type@=a@Ab@Sc/");
    directed_pkt("ty@Ape@=chatmsg/");
    directed_pkt("type@=loginresX/");
    directed_pkt("type@=aaaaaaaaaaaaaaaaaa/");
    directed_pkt("type@=rss/garbage@=uenter/");
    put_header();
    put_raw_str("type@=uenter/");
    put_raw(8'hff);
    flush_packet();
    wait_idle();

    random_phase(90, 10, 10);
    random_phase(70, 0, 0);

    // output held off while input keeps streaming
    @(negedge clk);
    tx_gap_max = 0;
    rx_gap_max = 0;
    holds_asked++;
    repeat (12) begin
      if ($urandom_range(0, 1)) header_only_pkt();
      else kv_pkt();
    end
    wait_idle();

    random_phase(50, 3, 10);
    random_phase(30, 10, 0);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes in %0d packets, one long output stall", bytes_taken,
             classes_seen);
    $display("classes: invalid %0d chat %0d login %0d stat %0d enter %0d other %0d",
             class_hits[CLS_INVALID], class_hits[CLS_CHAT], class_hits[CLS_LOGIN],
             class_hits[CLS_STAT], class_hits[CLS_ENTER], class_hits[CLS_OTHER]);
    if (err_count == 0 && pending_classes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
